// File: src/first_fit_allocator_defrag_macros.svh
// Assertion macros used by the allocator RTL.
// Included by the controller, which carries the concurrent checks; no other dependencies.
`ifndef FIRST_FIT_ALLOCATOR_DEFRAG_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_DEFRAG_MACROS_SVH
`ifndef SYNTHESIS
// Check that holds outside reset.
`define FFA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that holds at every edge, reset included.
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFA_ASSERT(label, clk, rst, prop, msg)
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/ffa_pkg.sv
// Shared types and codes of the first-fit allocator.
// No dependencies; used by the controller and the top level.
package ffa_pkg;

  localparam int KIND_W   = 2;
  localparam int SIZE_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 3;
  localparam int UNITS_W  = 8;

  localparam logic [UNITS_W-1:0] UNITS_RESET = 8'd100;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_ALLOC   = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAIL    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERASED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DEFRAG  = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_FILL,
    S_E_SCAN,
    S_D_SCAN,
    S_D_ZERO
  } state_t;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  block_id;
  } res_t;

endpackage

// File: src/first_fit_allocator_defrag.sv
// First-fit cell allocator with compaction; one owner map RAM, one sequencer.
// Allocate scans the usable cells for a free run and fills it; erase scans every cell;
// defragment packs owned cells down, then zeroes the rest; quick failures skip the scan.
// One item at a time: start is taken only while idle, which includes the cycle of done.
// done pulses once per result and the receiver cannot stall; the map ports set pace.
// After rst the map is cleared one cell a cycle, with busy high until it is done.
module first_fit_allocator_defrag #(
  parameter int MEM_CELLS = 128,
  parameter int ID_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffa_pkg::KIND_W-1:0]    kind,
  input  logic [ffa_pkg::SIZE_W-1:0]    alloc_size,
  input  logic [ffa_pkg::FIELD_W-1:0]   erase_id,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffa_pkg::UNITS_W-1:0]   cfg_data,
  output logic                          done,
  output logic [ffa_pkg::STATUS_W-1:0]  status,
  output logic [ffa_pkg::FIELD_W-1:0]   block_id
);

  localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;

  logic [ffa_pkg::UNITS_W-1:0] memory_units;
  ffa_pkg::res_t               res;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ID_WIDTH-1:0]         ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [ID_WIDTH-1:0]         ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_units <= ffa_pkg::UNITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      memory_units <= cfg_data;
    end
  end

  ffa_ctrl #(
    .MEM_CELLS (MEM_CELLS),
    .ID_WIDTH  (ID_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .alloc_size   (alloc_size),
    .erase_id     (erase_id),
    .memory_units (memory_units),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  ffa_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (MEM_CELLS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign done     = res.done;
  assign status   = res.status;
  assign block_id = res.block_id;

endmodule

// File: src/ffa_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ffa_ctrl.sv
// Sequencer of the allocator: clear pass, first-fit scan and fill, erase, compaction.
// Depends on ffa_pkg and the assertion macros; drives the owner map RAM.
`include "first_fit_allocator_defrag_macros.svh"
module ffa_ctrl #(
  parameter int MEM_CELLS = 128,
  parameter int ID_WIDTH  = 16,
  parameter int AW        = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ffa_pkg::KIND_W-1:0]     kind,
  input  logic [ffa_pkg::SIZE_W-1:0]     alloc_size,
  input  logic [ffa_pkg::FIELD_W-1:0]    erase_id,
  input  logic [ffa_pkg::UNITS_W-1:0]    memory_units,
  output ffa_pkg::res_t                  res,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_waddr,
  output logic [ID_WIDTH-1:0]            ram_wdata,
  output logic                           ram_re,
  output logic [AW-1:0]                  ram_raddr,
  input  logic [ID_WIDTH-1:0]            ram_rdata
);

  localparam int CNTW = $clog2(MEM_CELLS + 1);
  localparam int LW   = (CNTW > ffa_pkg::UNITS_W) ? CNTW : ffa_pkg::UNITS_W;
  localparam int MW   = (ID_WIDTH > ffa_pkg::FIELD_W) ? ID_WIDTH : ffa_pkg::FIELD_W;
  localparam logic [CNTW-1:0] CELLS = CNTW'(MEM_CELLS);

  ffa_pkg::state_t state, state_next;
  ffa_pkg::res_t   res_next;

  logic [CNTW-1:0]              cnt, cnt_next;
  logic [CNTW-1:0]              wptr, wptr_next;
  logic [CNTW-1:0]              run, run_next;
  logic [AW-1:0]                fill_end, fill_end_next;
  logic [AW-1:0]                rd_idx, rd_idx_next;
  logic                         rd_valid, rd_valid_next;
  logic                         hit, hit_next;
  logic [ID_WIDTH:0]            next_id, next_id_next;
  logic [ffa_pkg::SIZE_W-1:0]   size_q, size_next;
  logic [ffa_pkg::FIELD_W-1:0]  target_q, target_next;

  logic [LW-1:0]   lim_ext;
  logic [CNTW-1:0] lim;
  logic [LW-1:0]   first_ext;
  logic [MW-1:0]   id_ext;
  logic [MW-1:0]   data_ext;
  logic [MW-1:0]   target_ext;
  logic            scan_end_lim;
  logic            scan_end_all;

  // Allocation searches only the usable cells; the register may exceed the capacity.
  assign lim_ext = (LW'(memory_units) < LW'(MEM_CELLS)) ? LW'(memory_units) : LW'(MEM_CELLS);
  assign lim     = lim_ext[CNTW-1:0];

  assign first_ext  = LW'(rd_idx) + LW'(1) - LW'(size_q);
  assign id_ext     = MW'(next_id[ID_WIDTH-1:0]);
  assign data_ext   = MW'(ram_rdata);
  assign target_ext = MW'(target_q);

  assign scan_end_lim = (cnt == lim) && !rd_valid;
  assign scan_end_all = (cnt == CELLS) && !rd_valid;

  assign busy      = (state != ffa_pkg::S_IDLE);
  assign ram_raddr = cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffa_pkg::S_CLEAR;
      wptr     <= '0;
      rd_valid <= 1'b0;
      next_id  <= (ID_WIDTH + 1)'(1);
      res      <= '0;
    end else begin
      state    <= state_next;
      wptr     <= wptr_next;
      rd_valid <= rd_valid_next;
      next_id  <= next_id_next;
      res      <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    run      <= run_next;
    fill_end <= fill_end_next;
    rd_idx   <= rd_idx_next;
    hit      <= hit_next;
    size_q   <= size_next;
    target_q <= target_next;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    wptr_next     = wptr;
    run_next      = run;
    fill_end_next = fill_end;
    hit_next      = hit;
    next_id_next  = next_id;
    size_next     = size_q;
    target_next   = target_q;
    rd_valid_next = 1'b0;
    rd_idx_next   = cnt[AW-1:0];
    res_next      = '0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wptr[AW-1:0];
    ram_wdata     = '0;

    case (state)
      ffa_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (wptr == CNTW'(MEM_CELLS - 1)) begin
          wptr_next  = '0;
          state_next = ffa_pkg::S_IDLE;
        end else begin
          wptr_next = wptr + CNTW'(1);
        end
      end

      ffa_pkg::S_IDLE: begin
        if (start) begin
          size_next   = alloc_size;
          target_next = erase_id;
          cnt_next    = '0;
          run_next    = '0;
          hit_next    = 1'b0;
          wptr_next   = '0;
          case (kind)
            ffa_pkg::KIND_ALLOC: begin
              if ((alloc_size == '0) || next_id[ID_WIDTH]) begin
                res_next.done   = 1'b1;
                res_next.status = ffa_pkg::STATUS_FAIL;
              end else begin
                state_next = ffa_pkg::S_A_SCAN;
              end
            end
            ffa_pkg::KIND_ERASE: begin
              if (erase_id == '0) begin
                res_next.done   = 1'b1;
                res_next.status = ffa_pkg::STATUS_ILLEGAL;
              end else begin
                state_next = ffa_pkg::S_E_SCAN;
              end
            end
            default: begin
              state_next = ffa_pkg::S_D_SCAN;
            end
          endcase
        end
      end

      ffa_pkg::S_A_SCAN: begin
        if (cnt < lim) begin
          ram_re        = 1'b1;
          rd_valid_next = 1'b1;
          cnt_next      = cnt + CNTW'(1);
        end
        if (rd_valid && (ram_rdata == '0)) begin
          run_next = run + CNTW'(1);
          if (LW'(run) + LW'(1) >= LW'(size_q)) begin
            // The run ending at this cell is long enough; claim its last size_q cells.
            fill_end_next = rd_idx;
            wptr_next     = first_ext[CNTW-1:0];
            state_next    = ffa_pkg::S_A_FILL;
          end
        end else if (rd_valid) begin
          run_next = '0;
        end else if (scan_end_lim) begin
          res_next.done   = 1'b1;
          res_next.status = ffa_pkg::STATUS_FAIL;
          state_next      = ffa_pkg::S_IDLE;
        end
      end

      ffa_pkg::S_A_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = next_id[ID_WIDTH-1:0];
        if (wptr[AW-1:0] == fill_end) begin
          res_next.done     = 1'b1;
          res_next.status   = ffa_pkg::STATUS_ALLOC;
          res_next.block_id = id_ext[ffa_pkg::FIELD_W-1:0];
          next_id_next      = next_id + (ID_WIDTH + 1)'(1);
          state_next        = ffa_pkg::S_IDLE;
        end else begin
          wptr_next = wptr + CNTW'(1);
        end
      end

      ffa_pkg::S_E_SCAN: begin
        if (cnt < CELLS) begin
          ram_re        = 1'b1;
          rd_valid_next = 1'b1;
          cnt_next      = cnt + CNTW'(1);
        end
        if (rd_valid && (data_ext == target_ext)) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx;
          hit_next  = 1'b1;
        end
        if (scan_end_all) begin
          res_next.done   = 1'b1;
          res_next.status = hit ? ffa_pkg::STATUS_ERASED : ffa_pkg::STATUS_ILLEGAL;
          state_next      = ffa_pkg::S_IDLE;
        end
      end

      ffa_pkg::S_D_SCAN: begin
        if (cnt < CELLS) begin
          ram_re        = 1'b1;
          rd_valid_next = 1'b1;
          cnt_next      = cnt + CNTW'(1);
        end
        // The write pointer never passes the cell just read, so no read sees a moved cell.
        if (rd_valid && (ram_rdata != '0)) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          wptr_next = wptr + CNTW'(1);
        end
        if (scan_end_all) begin
          state_next = ffa_pkg::S_D_ZERO;
        end
      end

      ffa_pkg::S_D_ZERO: begin
        if (wptr == CELLS) begin
          res_next.done   = 1'b1;
          res_next.status = ffa_pkg::STATUS_DEFRAG;
          state_next      = ffa_pkg::S_IDLE;
        end else begin
          ram_we    = 1'b1;
          wptr_next = wptr + CNTW'(1);
        end
      end

      default: begin
        state_next = ffa_pkg::S_IDLE;
      end
    endcase
  end

  `FFA_ASSERT(a_done_after_work, clk, rst, res.done |-> $past(state != ffa_pkg::S_IDLE) || $past(start), "result without a transfer")
  `FFA_ASSERT(a_id_only_on_alloc, clk, rst, (res.done && (res.status != ffa_pkg::STATUS_ALLOC)) |-> (res.block_id == '0), "block id on non-allocation result")
  `FFA_ASSERT(a_fill_in_run, clk, rst, (state == ffa_pkg::S_A_FILL) |-> (wptr[AW-1:0] <= fill_end), "fill pointer past end of run")
  `FFA_ASSERT(a_no_rw_collision, clk, rst, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "read and write of the same cell")
  `FFA_ASSERT(a_idle_no_write, clk, rst, (state == ffa_pkg::S_IDLE) |-> !ram_we, "owner map written while idle")

endmodule
